FILE: hw/rtl/fzri_pkg.sv
package fzri_pkg;

	localparam logic [16:0] ONE  = 17'd65536;
	localparam logic [16:0] HALF = 17'd32768;
	localparam int          RULE_TABLE = 27;

	typedef enum logic [1:0] {
		REG_GRAD_SPAN,
		REG_RAD_SPAN,
		REG_DEG_SPAN,
		REG_FIRE_THR
	} cfg_reg_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SCALE,
		ST_SC_STORE,
		ST_FZ_EVAL,
		ST_FZ_ACC,
		ST_FZ_DIV,
		ST_FZ_STORE,
		ST_RU_EVAL,
		ST_RU_ACC,
		ST_RU_MUL,
		ST_RU_FIRE,
		ST_CE_EVAL,
		ST_CE_ACC,
		ST_CE_MUL,
		ST_CE_SUM,
		ST_CE_DIV,
		ST_CE_STORE,
		ST_OUT_MUL,
		ST_DONE,
		ST_DIVW
	} state_t;

	typedef struct packed {
		logic [16:0] a;
		logic [16:0] b;
		logic [16:0] c;
		logic [16:0] d;
	} shape_t;

	typedef struct packed {
		logic [1:0]        nant;
		logic [0:2][2:0]   av;
		logic [0:2][2:0]   aset;
		logic [1:0]        ncon;
		logic [0:2][2:0]   cv;
		logic [0:2][2:0]   cset;
		logic [16:0]       w;
	} rule_t;

	localparam shape_t SHAPES [23] = '{
		'{17'd0,     17'd0,     17'd9830,  17'd19661},
		'{17'd9830,  17'd19661, 17'd19661, 17'd29491},
		'{17'd19661, 17'd32768, 17'd32768, 17'd45875},
		'{17'd36045, 17'd45875, 17'd45875, 17'd55706},
		'{17'd45875, 17'd55706, 17'd65536, 17'd65536},
		'{17'd0,     17'd0,     17'd19661, 17'd32768},
		'{17'd19661, 17'd32768, 17'd32768, 17'd45875},
		'{17'd32768, 17'd45875, 17'd45875, 17'd58982},
		'{17'd45875, 17'd58982, 17'd65536, 17'd65536},
		'{17'd0,     17'd0,     17'd13107, 17'd26214},
		'{17'd13107, 17'd26214, 17'd26214, 17'd39322},
		'{17'd26214, 17'd39322, 17'd39322, 17'd52429},
		'{17'd39322, 17'd52429, 17'd65536, 17'd65536},
		'{17'd0,     17'd0,     17'd16384, 17'd29491},
		'{17'd16384, 17'd29491, 17'd29491, 17'd42598},
		'{17'd29491, 17'd42598, 17'd42598, 17'd55706},
		'{17'd42598, 17'd55706, 17'd65536, 17'd65536},
		'{17'd0,     17'd0,     17'd19661, 17'd32768},
		'{17'd13107, 17'd32768, 17'd32768, 17'd52429},
		'{17'd32768, 17'd45875, 17'd65536, 17'd65536},
		'{17'd0,     17'd0,     17'd19661, 17'd32768},
		'{17'd19661, 17'd32768, 17'd32768, 17'd45875},
		'{17'd32768, 17'd45875, 17'd65536, 17'd65536}
	};

	localparam logic [4:0] IN_FIRST  [8] = '{5'd0, 5'd5, 5'd9, 5'd13, 5'd9, 5'd17, 5'd17, 5'd17};
	localparam logic [2:0] IN_COUNT  [8] = '{3'd5, 3'd4, 3'd4, 3'd4, 3'd4, 3'd3, 3'd3, 3'd3};
	localparam logic [4:0] OUT_FIRST [6] = '{5'd0, 5'd0, 5'd0, 5'd0, 5'd20, 5'd17};
	localparam logic [2:0] OUT_COUNT [6] = '{3'd5, 3'd5, 3'd5, 3'd5, 3'd3, 3'd3};

	localparam rule_t RULES [RULE_TABLE] = '{
		'{2'd2, '{3'd0, 3'd1, 3'd0}, '{3'd1, 3'd1, 3'd0}, 2'd1, '{3'd0, 3'd0, 3'd0}, '{3'd2, 3'd0, 3'd0}, 17'd52429},
		'{2'd2, '{3'd0, 3'd1, 3'd0}, '{3'd0, 3'd0, 3'd0}, 2'd1, '{3'd0, 3'd0, 3'd0}, '{3'd4, 3'd0, 3'd0}, 17'd58982},
		'{2'd2, '{3'd0, 3'd1, 3'd0}, '{3'd3, 3'd2, 3'd0}, 2'd1, '{3'd0, 3'd0, 3'd0}, '{3'd0, 3'd0, 3'd0}, 17'd45875},
		'{2'd2, '{3'd0, 3'd1, 3'd0}, '{3'd4, 3'd3, 3'd0}, 2'd1, '{3'd0, 3'd0, 3'd0}, '{3'd0, 3'd0, 3'd0}, 17'd65536},
		'{2'd2, '{3'd4, 3'd0, 3'd0}, '{3'd3, 3'd2, 3'd0}, 2'd1, '{3'd0, 3'd0, 3'd0}, '{3'd3, 3'd0, 3'd0}, 17'd39322},
		'{2'd1, '{3'd1, 3'd0, 3'd0}, '{3'd2, 3'd0, 3'd0}, 2'd1, '{3'd1, 3'd0, 3'd0}, '{3'd3, 3'd0, 3'd0}, 17'd52429},
		'{2'd1, '{3'd1, 3'd0, 3'd0}, '{3'd3, 3'd0, 3'd0}, 2'd1, '{3'd1, 3'd0, 3'd0}, '{3'd4, 3'd0, 3'd0}, 17'd65536},
		'{2'd2, '{3'd1, 3'd0, 3'd0}, '{3'd0, 3'd1, 3'd0}, 2'd1, '{3'd1, 3'd0, 3'd0}, '{3'd0, 3'd0, 3'd0}, 17'd45875},
		'{2'd2, '{3'd5, 3'd1, 3'd0}, '{3'd2, 3'd1, 3'd0}, 2'd1, '{3'd1, 3'd0, 3'd0}, '{3'd2, 3'd0, 3'd0}, 17'd39322},
		'{2'd1, '{3'd4, 3'd0, 3'd0}, '{3'd3, 3'd0, 3'd0}, 2'd1, '{3'd1, 3'd0, 3'd0}, '{3'd3, 3'd0, 3'd0}, 17'd45875},
		'{2'd1, '{3'd2, 3'd0, 3'd0}, '{3'd0, 3'd0, 3'd0}, 2'd2, '{3'd2, 3'd3, 3'd0}, '{3'd0, 3'd4, 3'd0}, 17'd58982},
		'{2'd2, '{3'd2, 3'd4, 3'd0}, '{3'd1, 3'd0, 3'd0}, 2'd2, '{3'd3, 3'd5, 3'd0}, '{3'd3, 3'd2, 3'd0}, 17'd52429},
		'{2'd2, '{3'd2, 3'd0, 3'd0}, '{3'd3, 3'd1, 3'd0}, 2'd1, '{3'd2, 3'd0, 3'd0}, '{3'd3, 3'd0, 3'd0}, 17'd39322},
		'{2'd1, '{3'd6, 3'd0, 3'd0}, '{3'd2, 3'd0, 3'd0}, 2'd1, '{3'd3, 3'd0, 3'd0}, '{3'd3, 3'd0, 3'd0}, 17'd45875},
		'{2'd2, '{3'd3, 3'd2, 3'd0}, '{3'd0, 3'd3, 3'd0}, 2'd1, '{3'd2, 3'd0, 3'd0}, '{3'd1, 3'd0, 3'd0}, 17'd52429},
		'{2'd2, '{3'd3, 3'd1, 3'd0}, '{3'd1, 3'd2, 3'd0}, 2'd1, '{3'd2, 3'd0, 3'd0}, '{3'd1, 3'd0, 3'd0}, 17'd45875},
		'{2'd2, '{3'd3, 3'd0, 3'd0}, '{3'd2, 3'd1, 3'd0}, 2'd1, '{3'd2, 3'd0, 3'd0}, '{3'd3, 3'd0, 3'd0}, 17'd39322},
		'{2'd2, '{3'd3, 3'd0, 3'd0}, '{3'd3, 3'd2, 3'd0}, 2'd1, '{3'd2, 3'd0, 3'd0}, '{3'd2, 3'd0, 3'd0}, 17'd32768},
		'{2'd1, '{3'd1, 3'd0, 3'd0}, '{3'd3, 3'd0, 3'd0}, 2'd3, '{3'd4, 3'd1, 3'd0}, '{3'd2, 3'd4, 3'd0}, 17'd65536},
		'{2'd1, '{3'd2, 3'd0, 3'd0}, '{3'd0, 3'd0, 3'd0}, 2'd2, '{3'd4, 3'd3, 3'd0}, '{3'd2, 3'd4, 3'd0}, 17'd65536},
		'{2'd2, '{3'd3, 3'd2, 3'd0}, '{3'd0, 3'd1, 3'd0}, 2'd2, '{3'd4, 3'd2, 3'd0}, '{3'd2, 3'd0, 3'd0}, 17'd58982},
		'{2'd2, '{3'd4, 3'd2, 3'd0}, '{3'd3, 3'd1, 3'd0}, 2'd2, '{3'd4, 3'd3, 3'd0}, '{3'd1, 3'd3, 3'd0}, 17'd52429},
		'{2'd2, '{3'd6, 3'd0, 3'd0}, '{3'd2, 3'd1, 3'd0}, 2'd1, '{3'd4, 3'd0, 3'd0}, '{3'd1, 3'd0, 3'd0}, 17'd45875},
		'{2'd1, '{3'd2, 3'd0, 3'd0}, '{3'd1, 3'd0, 3'd0}, 2'd1, '{3'd5, 3'd0, 3'd0}, '{3'd2, 3'd0, 3'd0}, 17'd52429},
		'{2'd2, '{3'd4, 3'd7, 3'd0}, '{3'd0, 3'd2, 3'd0}, 2'd1, '{3'd5, 3'd0, 3'd0}, '{3'd2, 3'd0, 3'd0}, 17'd45875},
		'{2'd3, '{3'd2, 3'd0, 3'd1}, '{3'd2, 3'd2, 3'd1}, 2'd1, '{3'd5, 3'd0, 3'd0}, '{3'd0, 3'd0, 3'd0}, 17'd32768},
		'{2'd2, '{3'd7, 3'd6, 3'd0}, '{3'd2, 3'd2, 3'd0}, 2'd1, '{3'd5, 3'd0, 3'd0}, '{3'd2, 3'd0, 3'd0}, 17'd52429}
	};

endpackage

FILE: hw/rtl/fuzzy_rule_inference_engine.sv
// Fuzzy rule inference engine: one request of eight sensor readings in, one request of six
// scaled centroids and a fired-rule count out. Levels and centroids are Q1.16, boost and
// cooling Q2.16, orbit_delta signed in units of 2^-16. The block takes one request at a
// time; s_tready is high only while it is idle. Every division (raw scaling, membership
// slopes, input re-crisping, output centroids) runs on one shared restoring divider at one
// quotient bit per cycle. The three raw readings are scaled first, each by its span.
// Fuzzification then evaluates every membership of each input, dividing only where the
// input lands on a slope, and re-crisps each input from its weighted sum; each rule takes
// the minimum of its antecedents, is weighted and fires above the threshold. Each output
// then walks CENTROID_POINTS samples over all of its sets (five for the first four outputs,
// three for the last two), dividing for each set with nonzero strength whose slope holds
// the sample (at most two), and ends with a final division. A finished result waits in the
// output register while the next request is taken.
module fuzzy_rule_inference_engine #(
	parameter int CENTROID_POINTS = 1000,
	parameter int RULE_COUNT      = 27
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// energy, temperature, structure, orbit, solar levels (17b each), gradient, dose, wear raw (16b)
	input  logic [135:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// boost(18), cooling(18), orbit_delta(14), mitigation(17), emergency(17), upkeep(17), fired(5)
	output logic [111:0] m_tdata,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [16:0]  cfg_wdata
);
	import fzri_pkg::*;

	localparam int CENT_W = $clog2(CENTROID_POINTS);
	localparam int NUM_W  = 32 + CENT_W;
	localparam int DEN_W  = 17 + CENT_W;
	localparam int NRULES = (RULE_COUNT < RULE_TABLE) ? RULE_COUNT : RULE_TABLE;
	localparam logic [15:0]       X_STEP = 16'(65536 / CENTROID_POINTS);
	localparam logic [CENT_W:0]   R_STEP = (CENT_W+1)'(65536 % CENTROID_POINTS);
	localparam logic [CENT_W:0]   PTS    = (CENT_W+1)'(CENTROID_POINTS);

	state_t state_q, state_d, ret_q, ret_d;

	logic [15:0] grad_span_q, rad_span_q, deg_span_q;
	logic [16:0] fire_thr_q;

	logic [16:0] level_q [8];
	logic [16:0] crisp_q [8];
	logic [16:0] str_q [6][5];
	logic [16:0] str_n [6][5];
	logic [16:0] cent_q [6];

	logic [2:0]  i_q, j_q, v_q;
	logic [1:0]  a_q;
	logic [4:0]  r_q;
	logic [4:0]  fired_q;
	logic [16:0] m_q, act_q, agg_q;
	logic [19:0] sum_q;
	logic [21:0] wsum_q;
	logic [CENT_W-1:0] pt_q, xr_q;
	logic [15:0] x_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;

	logic [31:0] div_rem_q, div_quo_q, div_den_q;
	logic [47:0] div_lo_q;
	logic [5:0]  div_cnt_q;
	logic        div_start;
	logic [31:0] div_hi, div_den;
	logic [47:0] div_lo;
	logic [5:0]  div_steps;
	logic [32:0] div_t;

	logic [16:0] mul_a, mul_b;
	logic [33:0] mul_q;

	logic [4:0]  mem_s;
	logic [16:0] mem_x, mem_fast, mem_hi, mem_den;
	logic        mem_div;
	shape_t      sh;
	rule_t       rl;

	logic [16:0] act2, m2;
	logic [15:0] span_sel;
	logic [2:0]  n_sel;
	logic [CENT_W:0] xr_sum;
	logic        accept;

	assign accept = s_tvalid && s_tready;
	assign rl     = RULES[r_q];
	assign act2   = mul_q[32:16];
	assign m2     = (m_q < str_q[v_q][j_q]) ? m_q : str_q[v_q][j_q];
	assign n_sel  = IN_COUNT[i_q];
	assign xr_sum = {1'b0, xr_q} + R_STEP;
	assign div_t  = {div_rem_q, div_lo_q[47]};

	always_comb begin
		case (i_q)
			3'd5:    span_sel = grad_span_q;
			3'd6:    span_sel = rad_span_q;
			default: span_sel = deg_span_q;
		endcase
		if (span_sel == 16'd0)
			span_sel = 16'd1;
	end

	// membership classification
	always_comb begin
		sh       = SHAPES[mem_s];
		mem_div  = 1'b0;
		mem_fast = 17'd0;
		mem_hi   = 17'd0;
		mem_den  = 17'd1;
		if (mem_x >= sh.b && mem_x <= sh.c) begin
			mem_fast = ONE;
		end else if (mem_x <= sh.a || mem_x >= sh.d) begin
			mem_fast = 17'd0;
		end else if (mem_x < sh.b) begin
			mem_div = 1'b1;
			mem_hi  = mem_x - sh.a;
			mem_den = sh.b - sh.a;
		end else begin
			mem_div = 1'b1;
			mem_hi  = sh.d - mem_x;
			mem_den = sh.d - sh.c;
		end
	end

	always_comb begin
		for (int vi = 0; vi < 6; vi++) begin
			for (int si = 0; si < 5; si++) begin
				str_n[vi][si] = str_q[vi][si];
				for (int k = 0; k < 3; k++) begin
					if (2'(k) < rl.ncon && rl.cv[k] == 3'(vi) && rl.cset[k] == 3'(si)
					    && act2 > str_n[vi][si])
						str_n[vi][si] = act2;
				end
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (s_tvalid) state_d = ST_SCALE;
			ST_SCALE:    state_d = ST_DIVW;
			ST_SC_STORE: state_d = (i_q == 3'd7) ? ST_FZ_EVAL : ST_SCALE;
			ST_FZ_EVAL:  state_d = mem_div ? ST_DIVW : ST_FZ_ACC;
			ST_FZ_ACC:   state_d = (j_q == n_sel - 3'd1) ? ST_FZ_DIV : ST_FZ_EVAL;
			ST_FZ_DIV: begin
				if (sum_q != 20'd0)
					state_d = ST_DIVW;
				else
					state_d = (i_q == 3'd7) ? ST_RU_EVAL : ST_FZ_EVAL;
			end
			ST_FZ_STORE: state_d = (i_q == 3'd7) ? ST_RU_EVAL : ST_FZ_EVAL;
			ST_RU_EVAL:  state_d = mem_div ? ST_DIVW : ST_RU_ACC;
			ST_RU_ACC:   state_d = (a_q == rl.nant - 2'd1) ? ST_RU_MUL : ST_RU_EVAL;
			ST_RU_MUL:   state_d = ST_RU_FIRE;
			ST_RU_FIRE:  state_d = (r_q == 5'(NRULES - 1)) ? ST_CE_EVAL : ST_RU_EVAL;
			ST_CE_EVAL: begin
				if (str_q[v_q][j_q] != 17'd0 && mem_div)
					state_d = ST_DIVW;
				else
					state_d = ST_CE_ACC;
			end
			ST_CE_ACC:   state_d = (j_q == OUT_COUNT[v_q] - 3'd1) ? ST_CE_MUL : ST_CE_EVAL;
			ST_CE_MUL:   state_d = ST_CE_SUM;
			ST_CE_SUM:   state_d = (pt_q == CENT_W'(CENTROID_POINTS - 1)) ? ST_CE_DIV : ST_CE_EVAL;
			ST_CE_DIV: begin
				if (den_q != '0)
					state_d = ST_DIVW;
				else
					state_d = (v_q == 3'd5) ? ST_OUT_MUL : ST_CE_EVAL;
			end
			ST_CE_STORE: state_d = (v_q == 3'd5) ? ST_OUT_MUL : ST_CE_EVAL;
			ST_OUT_MUL:  state_d = ST_DONE;
			ST_DONE:     if (!m_tvalid || m_tready) state_d = ST_IDLE;
			ST_DIVW:     if (div_cnt_q == 6'd0) state_d = ret_q;
			default:     state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_tready  = 1'b0;
		div_start = 1'b0;
		div_hi    = 32'd0;
		div_lo    = 48'd0;
		div_steps = 6'd16;
		div_den   = {15'd0, mem_den};
		ret_d     = ret_q;
		mul_a     = 17'd0;
		mul_b     = 17'd0;
		mem_s     = 5'd0;
		mem_x     = 17'd0;
		case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_SCALE: begin
				div_start = 1'b1;
				div_lo    = {level_q[i_q][15:0], 32'd0};
				div_steps = 6'd32;
				div_den   = {16'd0, span_sel};
				ret_d     = ST_SC_STORE;
			end
			ST_FZ_EVAL: begin
				mem_s     = IN_FIRST[i_q] + 5'(j_q);
				mem_x     = level_q[i_q];
				div_start = mem_div;
				div_hi    = {15'd0, mem_hi};
				ret_d     = ST_FZ_ACC;
			end
			ST_FZ_DIV: begin
				div_start = (sum_q != 20'd0);
				div_hi    = {10'd0, 22'(wsum_q >> 1)};
				div_lo    = {wsum_q[0], 47'd0};
				div_steps = 6'd17;
				div_den   = {10'd0, 22'(sum_q) * 22'(n_sel - 3'd1)};
				ret_d     = ST_FZ_STORE;
			end
			ST_RU_EVAL: begin
				mem_s     = IN_FIRST[rl.av[a_q]] + 5'(rl.aset[a_q]);
				mem_x     = crisp_q[rl.av[a_q]];
				div_start = mem_div;
				div_hi    = {15'd0, mem_hi};
				ret_d     = ST_RU_ACC;
			end
			ST_RU_MUL: begin
				mul_a = act_q;
				mul_b = rl.w;
			end
			ST_CE_EVAL: begin
				mem_s     = OUT_FIRST[v_q] + 5'(j_q);
				mem_x     = {1'b0, x_q};
				div_start = mem_div && (str_q[v_q][j_q] != 17'd0);
				div_hi    = {15'd0, mem_hi};
				ret_d     = ST_CE_ACC;
			end
			ST_CE_MUL: begin
				mul_a = {1'b0, x_q};
				mul_b = agg_q;
			end
			ST_CE_DIV: begin
				div_start = (den_q != '0);
				div_hi    = 32'(num_q >> 16);
				div_lo    = {num_q[15:0], 32'd0};
				div_den   = 32'(den_q);
				ret_d     = ST_CE_STORE;
			end
			ST_OUT_MUL, ST_DONE: begin
				mul_a = cent_q[2];
				mul_b = 17'd13108;
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ret_q       <= ST_IDLE;
			m_tvalid    <= 1'b0;
			div_cnt_q   <= 6'd0;
			grad_span_q <= 16'd25600;
			rad_span_q  <= 16'd65535;
			deg_span_q  <= 16'd2560;
			fire_thr_q  <= 17'd655;
		end else begin
			state_q <= state_d;
			if (div_start) begin
				ret_q     <= ret_d;
				div_cnt_q <= div_steps;
			end else if (div_cnt_q != 6'd0) begin
				div_cnt_q <= div_cnt_q - 6'd1;
			end
			if (state_q == ST_DONE && (!m_tvalid || m_tready))
				m_tvalid <= 1'b1;
			else if (m_tready)
				m_tvalid <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					REG_GRAD_SPAN: grad_span_q <= cfg_wdata[15:0];
					REG_RAD_SPAN:  rad_span_q  <= cfg_wdata[15:0];
					REG_DEG_SPAN:  deg_span_q  <= cfg_wdata[15:0];
					REG_FIRE_THR:  fire_thr_q  <= cfg_wdata;
					default: ;
				endcase
			end
		end
	end

	// shared divider and multiplier
	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
		if (div_start) begin
			div_rem_q <= div_hi;
			div_lo_q  <= div_lo;
			div_quo_q <= 32'd0;
			div_den_q <= div_den;
		end else if (div_cnt_q != 6'd0) begin
			div_lo_q <= {div_lo_q[46:0], 1'b0};
			if (div_t >= {1'b0, div_den_q}) begin
				div_rem_q <= 32'(div_t - {1'b0, div_den_q});
				div_quo_q <= {div_quo_q[30:0], 1'b1};
			end else begin
				div_rem_q <= div_t[31:0];
				div_quo_q <= {div_quo_q[30:0], 1'b0};
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					for (int k = 0; k < 5; k++)
						level_q[k] <= (s_tdata[k*17 +: 17] > ONE) ? ONE : s_tdata[k*17 +: 17];
					for (int k = 0; k < 3; k++)
						level_q[5+k] <= {1'b0, s_tdata[85 + k*16 +: 16]};
					i_q <= 3'd5;
				end
			end
			ST_SC_STORE: begin
				level_q[i_q] <= (div_quo_q > 32'(ONE)) ? ONE : div_quo_q[16:0];
				i_q    <= i_q + 3'd1;
				j_q    <= 3'd0;
				sum_q  <= 20'd0;
				wsum_q <= 22'd0;
			end
			ST_FZ_EVAL, ST_RU_EVAL: begin
				if (!mem_div)
					m_q <= mem_fast;
			end
			ST_CE_EVAL: begin
				if (str_q[v_q][j_q] == 17'd0)
					m_q <= 17'd0;
				else if (!mem_div)
					m_q <= mem_fast;
			end
			ST_DIVW: begin
				m_q <= div_quo_q[16:0];
			end
			ST_FZ_ACC: begin
				sum_q  <= sum_q + 20'(m_q);
				wsum_q <= wsum_q + 22'(m_q) * 22'(j_q);
				j_q    <= j_q + 3'd1;
			end
			ST_FZ_DIV, ST_FZ_STORE: begin
				if (state_q == ST_FZ_STORE)
					crisp_q[i_q] <= div_quo_q[16:0];
				else if (sum_q == 20'd0)
					crisp_q[i_q] <= HALF;
				if (state_q == ST_FZ_STORE || sum_q == 20'd0) begin
					i_q    <= i_q + 3'd1;
					j_q    <= 3'd0;
					sum_q  <= 20'd0;
					wsum_q <= 22'd0;
					r_q    <= 5'd0;
					a_q    <= 2'd0;
					act_q  <= ONE;
					fired_q <= 5'd0;
					for (int vi = 0; vi < 6; vi++)
						for (int si = 0; si < 5; si++)
							str_q[vi][si] <= 17'd0;
				end
			end
			ST_RU_ACC: begin
				if (m_q < act_q)
					act_q <= m_q;
				a_q <= a_q + 2'd1;
			end
			ST_RU_FIRE: begin
				if (act2 > fire_thr_q) begin
					fired_q <= fired_q + 5'd1;
					str_q   <= str_n;
				end
				r_q   <= r_q + 5'd1;
				a_q   <= 2'd0;
				act_q <= ONE;
				v_q   <= 3'd0;
				pt_q  <= '0;
				xr_q  <= '0;
				x_q   <= 16'd0;
				j_q   <= 3'd0;
				agg_q <= 17'd0;
				num_q <= '0;
				den_q <= '0;
			end
			ST_CE_ACC: begin
				if (m2 > agg_q)
					agg_q <= m2;
				j_q <= j_q + 3'd1;
			end
			ST_CE_SUM: begin
				num_q <= num_q + NUM_W'(mul_q);
				den_q <= den_q + DEN_W'(agg_q);
				agg_q <= 17'd0;
				j_q   <= 3'd0;
				pt_q  <= pt_q + CENT_W'(1);
				if (xr_sum >= PTS) begin
					xr_q <= CENT_W'(xr_sum - PTS);
					x_q  <= x_q + X_STEP + 16'd1;
				end else begin
					xr_q <= CENT_W'(xr_sum);
					x_q  <= x_q + X_STEP;
				end
			end
			ST_CE_DIV, ST_CE_STORE: begin
				if (state_q == ST_CE_STORE)
					cent_q[v_q] <= div_quo_q[16:0];
				else if (den_q == '0)
					cent_q[v_q] <= HALF;
				if (state_q == ST_CE_STORE || den_q == '0) begin
					v_q   <= v_q + 3'd1;
					pt_q  <= '0;
					xr_q  <= '0;
					x_q   <= 16'd0;
					j_q   <= 3'd0;
					agg_q <= 17'd0;
					num_q <= '0;
					den_q <= '0;
				end
			end
			ST_DONE: begin
				if (!m_tvalid || m_tready) begin
					m_tdata <= {6'd0, fired_q, cent_q[5], cent_q[4], cent_q[3],
					            14'(mul_q[33:16]) - 14'd6554,
					            18'(HALF) + 18'(cent_q[1]) + 18'(cent_q[1] >> 1),
					            18'(HALF) + 18'(cent_q[0]) + 18'(cent_q[0] >> 1)};
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTH
	a_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> div_cnt_q == 6'd0)
		else $error("divider busy while idle");
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("second request taken during processing");
	a_fired: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE |-> fired_q <= 5'(NRULES))
		else $error("fired count exceeds rule count");
	a_sample: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CE_EVAL |-> {1'b0, xr_q} < PTS)
		else $error("sample remainder out of range");
`endif

endmodule
